// ----- rtl/core/dsp_pkg.sv -----
// Package with shared types and constants for the drum sample player.
`timescale 1ns / 1ps
package dsp_pkg;
	localparam int Voices   = 16;
	localparam int Slots    = 32;
	localparam int PcmWords = 65536;
	localparam int VW  = $clog2(Voices);
	localparam int SW  = $clog2(Slots);
	localparam int AW  = $clog2(PcmWords);
	localparam int QDEPTH = 4;
	localparam int QW  = $clog2(QDEPTH);

	typedef enum logic [2:0] {
		MODE_NOTE_ON  = 3'd0,
		MODE_TICK     = 3'd1,
		MODE_ALL_OFF  = 3'd2,
		MODE_LOAD_PCM = 3'd3,
		MODE_LOAD_SLOT = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		REG_BASE_NOTE    = 2'd0,
		REG_LOADED_SLOTS = 2'd1,
		REG_MASTER_GAIN  = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic [2:0]         mode;
		logic [6:0]         note;
		logic [6:0]         velocity;
		logic [4:0]         slot_index;
		logic [15:0]        slot_start;
		logic [16:0]        slot_frames;
		logic [17:0]        slot_step;
		logic [15:0]        pcm_address;
		logic signed [15:0] pcm_value;
	} in_item_t;

	typedef struct packed {
		logic signed [19:0] mix_out;
		logic [4:0]         active_voices;
	} out_item_t;

	// Classified command handed from the front end to the back end.
	typedef enum logic [1:0] {
		CMD_NOTE_ON  = 2'd0,
		CMD_TICK     = 2'd1,
		CMD_ALL_OFF  = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t    kind;
		logic [SW-1:0] slot;
		logic [15:0]  gain;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ALLOC,
		ST_FETCH,
		ST_READ,
		ST_INTERP,
		ST_ACC,
		ST_MIX,
		ST_OUT
	} be_state_t;
endpackage

// ----- rtl/core/dsp_front.sv -----
// Front end: takes requests, runs loads, maps note-ons and queues voice commands.
`timescale 1ns / 1ps
module dsp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  dsp_pkg::in_item_t req,
	output logic              busy,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	output logic              pcm_we,
	output logic [dsp_pkg::AW-1:0] pcm_waddr,
	output logic [15:0]       pcm_wdata,
	output logic              slot_we,
	output logic [dsp_pkg::SW-1:0] slot_waddr,
	output logic [50:0]       slot_wdata,
	output logic [15:0]       master_gain,
	output logic              cmd_valid,
	output dsp_pkg::cmd_t     cmd,
	input  logic              cmd_pop,
	input  logic              back_idle
);
	import dsp_pkg::*;

	logic [6:0]  base_note_q;
	logic [5:0]  loaded_slots_q;
	logic [15:0] master_gain_q;
	cmd_t        fifo_q [QDEPTH];
	logic [QW-1:0] wr_q, rd_q;
	logic [QW:0] cnt_q;
	logic        accept, push, note_ok, is_load;
	logic [7:0]  slot_w;
	logic [21:0] vel_prod;
	logic [44:0] vel_quot;
	logic [15:0] gain_w;
	cmd_t        cmd_w;

	assign is_load = (req.mode == MODE_LOAD_PCM) || (req.mode == MODE_LOAD_SLOT);
	// Loads write the memories directly, so they wait until every queued command has run.
	assign busy   = (cnt_q == (QW+1)'(QDEPTH)) || (is_load && (cnt_q != '0 || !back_idle));
	assign accept = start && !busy;

	always_comb begin
		slot_w  = {1'b0, req.note} - {1'b0, base_note_q};
		note_ok = (req.note >= base_note_q) && ({2'b0, slot_w[5:0]} == slot_w)
			&& (slot_w[5:0] < loaded_slots_q) && (32'(slot_w) < Slots);
		// Rounded 24576*v/127: the quotient is below 2^15, found by multiply by reciprocal.
		// The reciprocal is exact for every product below 2^22.
		vel_prod = 22'(24576) * 22'(req.velocity) + 22'd63;
		vel_quot = 45'(vel_prod) * 45'(23'd4227331);
		gain_w   = 16'd8192 + vel_quot[44:29];
		cmd_w.slot = slot_w[SW-1:0];
		cmd_w.gain = gain_w;
		push = 1'b0;
		cmd_w.kind = CMD_TICK;
		unique case (req.mode)
			MODE_NOTE_ON: begin cmd_w.kind = CMD_NOTE_ON; push = accept && note_ok; end
			MODE_TICK:    begin cmd_w.kind = CMD_TICK;    push = accept; end
			MODE_ALL_OFF: begin cmd_w.kind = CMD_ALL_OFF; push = accept; end
			default: ;
		endcase
	end

	assign pcm_we     = accept && req.mode == MODE_LOAD_PCM;
	assign pcm_waddr  = req.pcm_address[AW-1:0];
	assign pcm_wdata  = req.pcm_value;
	assign slot_we    = accept && req.mode == MODE_LOAD_SLOT;
	assign slot_waddr = req.slot_index[SW-1:0];
	assign slot_wdata = {req.slot_start, req.slot_frames, req.slot_step};
	assign master_gain = master_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_note_q    <= 7'd36;
			loaded_slots_q <= 6'd0;
			master_gain_q  <= 16'd16384;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BASE_NOTE:    base_note_q    <= cfg_data[6:0];
				REG_LOADED_SLOTS: loaded_slots_q <= cfg_data[5:0];
				REG_MASTER_GAIN:  master_gain_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + QW'(1);
			if (cmd_pop) rd_q <= rd_q + QW'(1);
			cnt_q <= cnt_q + (QW+1)'(push) - (QW+1)'(cmd_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= cmd_w;
	end

	assign cmd_valid = cnt_q != '0;
	assign cmd       = fifo_q[rd_q];
endmodule

// ----- rtl/core/dsp_back.sv -----
// Back end: voice allocation and the per-frame voice walk, mix and saturation.
`timescale 1ns / 1ps
module dsp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  dsp_pkg::cmd_t     cmd,
	output logic              cmd_pop,
	input  logic              pcm_we,
	input  logic [dsp_pkg::AW-1:0] pcm_waddr,
	input  logic [15:0]       pcm_wdata,
	input  logic              slot_we,
	input  logic [dsp_pkg::SW-1:0] slot_waddr,
	input  logic [50:0]       slot_wdata,
	input  logic [15:0]       master_gain,
	output logic              back_idle,
	output logic              done,
	output dsp_pkg::out_item_t result
);
	import dsp_pkg::*;

	logic [15:0] pcm_mem [PcmWords];
	logic [50:0] slot_mem [Slots];

	logic [Voices-1:0] act_q;
	logic [SW-1:0]     vslot_q [Voices];
	logic [32:0]       vpos_q  [Voices];
	logic [15:0]       vgain_q [Voices];
	logic [VW-1:0]     steal_q, vidx_q;
	be_state_t         state_q, state_d;
	logic [50:0]       slot_rd_q;
	logic [15:0]       a_q, b_q;
	logic              half_q;
	logic signed [40:0] sum_q;
	logic [VW:0]       count_q;
	logic signed [16:0] s_q;
	logic [AW-1:0]     addr_w;
	logic [16:0]       idx_w;
	logic              end_w;
	logic              same_hit, free_hit;
	logic [VW-1:0]     same_v, free_v, pick_v;
	logic signed [16:0] diff_w;
	logic signed [33:0] diff_prod;
	logic signed [16:0] interp_w;
	logic signed [33:0] contrib;
	logic signed [57:0] mix_w;
	logic signed [19:0] sat_w;
	logic              retire, advance;
	cmd_t              cmd_q;

	assign back_idle = state_q == ST_IDLE;

	always_ff @(posedge clk) begin
		if (pcm_we) pcm_mem[pcm_waddr] <= pcm_wdata;
		if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
	end

	// Memory reads, registered.
	always_comb begin
		idx_w  = vpos_q[vidx_q][32:16];
		addr_w = slot_rd_q[50:35] + AW'(idx_w) + AW'(half_q);
	end
	always_ff @(posedge clk) begin
		slot_rd_q <= slot_mem[vslot_q[vidx_q]];
		if (half_q) b_q <= pcm_mem[addr_w];
		else a_q <= pcm_mem[addr_w];
	end

	always_comb begin
		same_hit = 1'b0; free_hit = 1'b0; same_v = '0; free_v = '0;
		for (int i = Voices - 1; i >= 0; i--) begin
			if (act_q[i] && vslot_q[i] == cmd_q.slot) begin same_hit = 1'b1; same_v = VW'(i); end
			if (!act_q[i]) begin free_hit = 1'b1; free_v = VW'(i); end
		end
		priority if (same_hit) pick_v = same_v;
		else if (free_hit) pick_v = free_v;
		else pick_v = steal_q;
	end

	assign end_w = ({1'b0, idx_w} + 18'd1) >= {1'b0, slot_rd_q[34:18]};
	always_comb begin
		// s = a + floor(diff*f / 2^16).
		diff_w    = 17'($signed(b_q)) - 17'($signed(a_q));
		diff_prod = 34'(diff_w) * $signed({1'b0, vpos_q[vidx_q][15:0]});
		interp_w  = 17'($signed(a_q)) + 17'(diff_prod >>> 16);
		contrib   = 34'(s_q) * $signed({1'b0, vgain_q[vidx_q]});
		mix_w     = 58'(sum_q) * $signed({1'b0, master_gain});
		if ((mix_w >>> 14) > 58'sd524287) sat_w = 20'sd524287;
		else if ((mix_w >>> 14) < -58'sd524288) sat_w = -20'sd524288;
		else sat_w = 20'(mix_w >>> 14);
	end

	always_comb begin
		state_d = state_q; cmd_pop = 1'b0; retire = 1'b0; advance = 1'b0; done = 1'b0;
		unique case (state_q)
			ST_IDLE: if (cmd_valid) begin
				cmd_pop = 1'b1;
				unique case (cmd.kind)
					CMD_NOTE_ON: state_d = ST_ALLOC;
					CMD_TICK:    state_d = ST_FETCH;
					default:     state_d = ST_IDLE;
				endcase
			end
			ST_ALLOC: state_d = ST_IDLE;
			ST_FETCH: state_d = act_q[vidx_q] ? ST_READ : ST_ACC;
			ST_READ: begin
				if (end_w) begin retire = 1'b1; state_d = ST_ACC; end
				else if (half_q) state_d = ST_INTERP;
			end
			ST_INTERP: state_d = ST_ACC;
			ST_ACC: begin
				advance = 1'b1;
				state_d = (vidx_q == VW'(Voices - 1)) ? ST_MIX : ST_FETCH;
			end
			ST_MIX: state_d = ST_OUT;
			ST_OUT: begin done = 1'b1; state_d = ST_IDLE; end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE; act_q <= '0; steal_q <= '0; vidx_q <= '0; half_q <= 1'b0;
			sum_q <= '0; count_q <= '0; s_q <= '0;
			result <= '0;
			cmd_q <= '0;
			for (int i = 0; i < Voices; i++) begin
				vslot_q[i] <= '0; vpos_q[i] <= '0; vgain_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cmd_pop) begin
				cmd_q <= cmd;
				if (cmd.kind == CMD_ALL_OFF) act_q <= '0;
				vidx_q <= '0; sum_q <= '0; count_q <= '0; half_q <= 1'b0;
			end
			if (state_q == ST_ALLOC) begin
				act_q[pick_v]   <= 1'b1;
				vslot_q[pick_v] <= cmd_q.slot;
				vpos_q[pick_v]  <= '0;
				vgain_q[pick_v] <= cmd_q.gain;
				if (!same_hit && !free_hit) steal_q <= steal_q + VW'(1);
			end
			if (state_q == ST_FETCH) s_q <= '0;
			if (state_q == ST_READ) half_q <= !half_q && !end_w;
			if (retire) act_q[vidx_q] <= 1'b0;
			// Interpolation lands in ST_INTERP, the cycle after b is read.
			if (state_q == ST_INTERP) s_q <= interp_w;
			if (advance) begin
				if (state_q == ST_ACC && act_q[vidx_q]) begin
					sum_q <= sum_q + 41'(contrib >>> 15);
					count_q <= count_q + (VW+1)'(1);
					vpos_q[vidx_q] <= vpos_q[vidx_q] + 33'(slot_rd_q[17:0]);
				end
				vidx_q <= vidx_q + VW'(1);
				half_q <= 1'b0;
			end
			if (state_q == ST_MIX) result <= '{mix_out: sat_w, active_voices: 5'(count_q)};
		end
	end
endmodule

// ----- rtl/core/drum_sample_player_top.sv -----
// Top level of the drum sample player.
`timescale 1ns / 1ps
// One-shot drum sampler with 16 voices. A request is taken when start is high and
// busy low. Note-on, tick and all-off requests pass through a four-entry queue to the
// voice engine, so busy rises for them only when that queue is full; a load waits until
// the queue is empty and the engine idle, then writes its memory as it is taken. A note-on
// with no loaded slot is dropped; the engine pops others and gives each a voice in ALLOC.
// For a tick it walks every voice: FETCH and ACC for a silent one, FETCH, READ, INTERP and
// ACC for a playing one, which makes two reads from the single PCM memory port (FETCH,
// READ and ACC if it ends in this frame), then MIX registers the result. Each tick gives
// one result, shown for one cycle with done; the receiver cannot stall it.
module drum_sample_player_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  dsp_pkg::in_item_t  req,
	output logic               busy,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output logic               done,
	output dsp_pkg::out_item_t result
);
	import dsp_pkg::*;
	logic pcm_we, slot_we, cmd_valid, cmd_pop, back_idle;
	logic [AW-1:0] pcm_waddr;
	logic [15:0] pcm_wdata, master_gain;
	logic [SW-1:0] slot_waddr;
	logic [50:0] slot_wdata;
	cmd_t cmd;

	dsp_front u_front (.clk, .arst_n, .start, .req, .busy, .cfg_we, .cfg_index, .cfg_data,
		.pcm_we, .pcm_waddr, .pcm_wdata, .slot_we, .slot_waddr, .slot_wdata,
		.master_gain, .cmd_valid, .cmd, .cmd_pop, .back_idle);
	dsp_back u_back (.clk, .arst_n, .cmd_valid, .cmd, .cmd_pop, .pcm_we, .pcm_waddr,
		.pcm_wdata, .slot_we, .slot_waddr, .slot_wdata, .master_gain, .back_idle,
		.done, .result);
endmodule

// ----- rtl/core/dsp_checker.sv -----
// Port-level checker for the drum sample player, bound to the top level.
`timescale 1ns / 1ps
module dsp_checker (
	input logic clk,
	input logic arst_n,
	input logic done,
	input logic busy,
	input dsp_pkg::out_item_t result
);
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done held two cycles");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.active_voices <= 5'd16) else $error("voice count too large");
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown(result)) else $error("unknown result");
	a_busy_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(busy)) else $error("unknown busy");
endmodule
bind drum_sample_player_top dsp_checker u_chk (.clk, .arst_n, .done, .busy, .result);
